@@ sv/pdlg_pkg.sv @@
`timescale 1ns / 1ps

package pdlg_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DIVIDE_KNOB      = 3'd0;
    localparam logic [2:0] CFG_INVERT_LOGIC     = 3'd1;
    localparam logic [2:0] CFG_GATE_SETS_LOOP   = 3'd2;
    localparam logic [2:0] CFG_COUNT_ONLY_GATED = 3'd3;
    localparam logic [2:0] CFG_PULSE_TICKS      = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MV_W        = 15;

    // Reset values of the configuration registers.
    localparam logic [8:0]  DIVIDE_KNOB_RST = 9'd16;
    localparam logic [15:0] PULSE_TICKS_RST = 16'd48;

    // Schmitt thresholds, gate-on level and CV full scale, in millivolts.
    localparam logic signed [MV_W-1:0] SCHMITT_LOW_MV  = 15'sd10;
    localparam logic signed [MV_W-1:0] SCHMITT_HIGH_MV = 15'sd2000;
    localparam logic signed [MV_W-1:0] GATE_ON_MV      = 15'sd200;
    localparam logic signed [MV_W-1:0] CV_FULL_MV      = 15'sd10000;

    // Divide count limits.
    localparam logic [8:0] TARGET_MIN = 9'd2;
    localparam logic [8:0] TARGET_MAX = 9'd256;

    // Settle delay: the delay ends on the tick whose count is at least this.
    localparam logic [2:0] SETTLE_TICKS = 3'd5;
    localparam logic [2:0] SETTLE_SAT   = 3'd7;

    // CV scaling: floor(cv * 254 / 10000) = floor(cv * 127 / 5000), done as a
    // multiply by a rounded-up reciprocal of 5000 and a shift.
    localparam int                CV_SHIFT   = 35;
    localparam longint unsigned   CV_RECIP   =
        ((64'd1 << CV_SHIFT) + 64'd4999) / 64'd5000;
    localparam logic [29:0]       CV_MULT    = 30'(CV_RECIP * 64'd127);
    localparam int                CV_PROD_W  = 44;

endpackage

@@ sv/pulse_divider_with_loop_gate.sv @@
`timescale 1ns / 1ps
// Each accepted input beat yields its result beat in the next cycle.
// Throughput: one input beat per cycle; the result register is the only
// stage, and it takes a new beat whenever it is empty or being drained.
// Reset (i_rst_n low, synchronous): detectors high, counters and flags clear,
// settle delay pending, configuration back to its defaults, no result valid.
module pulse_divider_with_loop_gate
    import pdlg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [MV_W-1:0] i_reset_mv,
    input  logic signed [MV_W-1:0] i_clock_mv,
    input  logic signed [MV_W-1:0] i_loop_mv,
    input  logic                   i_loop_connected,
    input  logic signed [MV_W-1:0] i_count_cv_mv,
    input  logic                   i_count_cv_connected,
    input  logic                   i_loop_button,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_pulse_out,
    output logic                   o_loop_on,
    output logic [7:0]             o_count_now,
    output logic [8:0]             o_target_count
);

    // Configuration.
    logic [8:0]  r_divide_knob;
    logic        r_invert_logic;
    logic        r_gate_sets_loop;
    logic        r_count_only_gated;
    logic [15:0] r_pulse_ticks;

    // Tick state.
    logic        r_reset_det, n_reset_det;
    logic        r_clock_det, n_clock_det;
    logic        r_loop_det, n_loop_det;
    logic        r_button_last, n_button_last;
    logic        r_loop_mode, n_loop_mode;
    logic        r_gate_seen, n_gate_seen;
    logic [7:0]  r_counter, n_counter;
    logic        r_fired_once, n_fired_once;
    logic        r_armed, n_armed;
    logic        r_settling, n_settling;
    logic [2:0]  r_settle_cnt, n_settle_cnt;
    logic [15:0] r_pulse_left, n_pulse_left;

    // Result register.
    logic        r_out_valid;
    logic        r_pulse_out, n_pulse_out;
    logic [8:0]  r_target;

    logic                 in_fire;
    logic [CV_PROD_W-1:0] cv_prod;
    logic [8:0]           cv_target;
    logic [8:0]           target;
    logic [8:0]           next_count;
    logic                 wrap;
    logic                 start;
    logic                 reset_edge;
    logic                 clock_edge;
    logic                 loop_edge;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Only the low 14 bits of a positive CV below full scale reach here.
    assign cv_prod   = CV_PROD_W'(i_count_cv_mv[13:0]) * CV_PROD_W'(CV_MULT);
    assign cv_target = TARGET_MIN + cv_prod[CV_SHIFT+8:CV_SHIFT];

    always_comb begin
        if (i_count_cv_connected) begin
            if (i_count_cv_mv <= 15'sd0) begin
                target = TARGET_MIN;
            end else if (i_count_cv_mv >= CV_FULL_MV) begin
                target = TARGET_MAX;
            end else begin
                target = cv_target;
            end
        end else if (r_divide_knob < TARGET_MIN) begin
            target = TARGET_MIN;
        end else if (r_divide_knob > TARGET_MAX) begin
            target = TARGET_MAX;
        end else begin
            target = r_divide_knob;
        end
    end

    always_comb begin
        n_reset_det   = r_reset_det;
        n_clock_det   = r_clock_det;
        n_loop_det    = r_loop_det;
        n_button_last = r_button_last;
        n_loop_mode   = r_loop_mode;
        n_gate_seen   = r_gate_seen;
        n_counter     = r_counter;
        n_fired_once  = r_fired_once;
        n_armed       = r_armed;
        n_settling    = r_settling;
        n_settle_cnt  = r_settle_cnt;
        n_pulse_left  = r_pulse_left;
        start         = 1'b0;
        reset_edge    = 1'b0;
        clock_edge    = 1'b0;
        loop_edge     = 1'b0;
        next_count    = 9'd0;
        wrap          = 1'b0;

        // Loop mode.
        if (i_loop_connected) begin
            if (r_gate_sets_loop) begin
                if (i_loop_mv > GATE_ON_MV) begin
                    n_loop_mode = 1'b1;
                    if (r_count_only_gated && !r_gate_seen) begin
                        n_counter    = 8'd0;
                        n_settle_cnt = 3'd0;
                        n_settling   = 1'b1;
                        n_gate_seen  = 1'b1;
                    end
                end else begin
                    n_loop_mode = 1'b0;
                    n_gate_seen = 1'b0;
                end
            end else begin
                if (r_loop_det) begin
                    if (i_loop_mv <= SCHMITT_LOW_MV) n_loop_det = 1'b0;
                end else if (i_loop_mv >= SCHMITT_HIGH_MV) begin
                    n_loop_det = 1'b1;
                    loop_edge  = 1'b1;
                end
                if (loop_edge) n_loop_mode = !r_loop_mode;
            end
        end else begin
            if (i_loop_button && !r_button_last) n_loop_mode = !r_loop_mode;
            n_button_last = i_loop_button;
        end

        // Reset input.
        if (r_reset_det) begin
            if (i_reset_mv <= SCHMITT_LOW_MV) n_reset_det = 1'b0;
        end else if (i_reset_mv >= SCHMITT_HIGH_MV) begin
            n_reset_det = 1'b1;
            reset_edge  = 1'b1;
        end
        if (reset_edge) begin
            n_counter    = 8'd0;
            n_fired_once = 1'b0;
            n_settle_cnt = 3'd0;
            n_settling   = 1'b1;
        end

        // Clock input.
        if (r_clock_det) begin
            if (i_clock_mv <= SCHMITT_LOW_MV) n_clock_det = 1'b0;
        end else if (i_clock_mv >= SCHMITT_HIGH_MV) begin
            n_clock_det = 1'b1;
            clock_edge  = 1'b1;
        end
        if (clock_edge) begin
            if (r_count_only_gated && r_gate_sets_loop && !n_gate_seen) begin
                n_armed = 1'b0;
            end else begin
                n_armed      = !n_fired_once || n_loop_mode;
                n_settle_cnt = 3'd0;
                n_settling   = 1'b1;
            end
        end

        // Settle delay, then one count.
        if (n_armed) begin
            if (n_settling) begin
                if (n_settle_cnt >= SETTLE_TICKS) n_settling = 1'b0;
                if (n_settle_cnt < SETTLE_SAT) n_settle_cnt = n_settle_cnt + 3'd1;
            end else begin
                next_count = {1'b0, n_counter} + 9'd1;
                wrap       = next_count >= target;
                if (wrap) begin
                    next_count   = 9'd0;
                    n_fired_once = 1'b1;
                end
                start     = r_invert_logic ? !wrap : wrap;
                n_counter = next_count[7:0];
                n_armed   = 1'b0;
            end
        end

        // Output pulse.
        if (start && r_pulse_ticks > n_pulse_left) n_pulse_left = r_pulse_ticks;
        n_pulse_out = n_pulse_left != 16'd0;
        if (n_pulse_out) n_pulse_left = n_pulse_left - 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide_knob      <= DIVIDE_KNOB_RST;
            r_invert_logic     <= 1'b0;
            r_gate_sets_loop   <= 1'b0;
            r_count_only_gated <= 1'b0;
            r_pulse_ticks      <= PULSE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIVIDE_KNOB:      r_divide_knob      <= i_cfg_data[8:0];
                CFG_INVERT_LOGIC:     r_invert_logic     <= i_cfg_data[0];
                CFG_GATE_SETS_LOOP:   r_gate_sets_loop   <= i_cfg_data[0];
                CFG_COUNT_ONLY_GATED: r_count_only_gated <= i_cfg_data[0];
                CFG_PULSE_TICKS:      r_pulse_ticks      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_det   <= 1'b1;
            r_clock_det   <= 1'b1;
            r_loop_det    <= 1'b1;
            r_button_last <= 1'b0;
            r_loop_mode   <= 1'b0;
            r_gate_seen   <= 1'b0;
            r_counter     <= 8'd0;
            r_fired_once  <= 1'b0;
            r_armed       <= 1'b0;
            r_settling    <= 1'b1;
            r_settle_cnt  <= 3'd0;
            r_pulse_left  <= 16'd0;
        end else if (in_fire) begin
            r_reset_det   <= n_reset_det;
            r_clock_det   <= n_clock_det;
            r_loop_det    <= n_loop_det;
            r_button_last <= n_button_last;
            r_loop_mode   <= n_loop_mode;
            r_gate_seen   <= n_gate_seen;
            r_counter     <= n_counter;
            r_fired_once  <= n_fired_once;
            r_armed       <= n_armed;
            r_settling    <= n_settling;
            r_settle_cnt  <= n_settle_cnt;
            r_pulse_left  <= n_pulse_left;
        end
    end

    // The result beat carries loop mode and counter as left by its tick, so
    // they are the state registers themselves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pulse_out <= n_pulse_out;
            r_target    <= target;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pulse_out    = r_pulse_out;
    assign o_loop_on      = r_loop_mode;
    assign o_count_now    = r_counter;
    assign o_target_count = r_target;

endmodule

@@ sv/pdlg_checker.sv @@
`timescale 1ns / 1ps
module pdlg_checker
    import pdlg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_pulse_out,
    input logic       o_loop_on,
    input logic [7:0] o_count_now,
    input logic [8:0] o_target_count
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pulse_out)
            && $stable(o_loop_on) && $stable(o_count_now)
            && $stable(o_target_count))
        else $error("result beat changed while stalled");

    // Input is taken whenever the result register is empty or draining.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow the result register");

    // Every accepted input beat yields a result beat on the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted beat produced no result");

    // The divide count shown with a valid result beat is within its range.
    a_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_target_count >= TARGET_MIN && o_target_count <= TARGET_MAX)
        else $error("divide count out of range");

endmodule

bind pulse_divider_with_loop_gate pdlg_checker u_pdlg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_pulse_out    (o_pulse_out),
    .o_loop_on      (o_loop_on),
    .o_count_now    (o_count_now),
    .o_target_count (o_target_count)
);
